// ===== rtl/pps_pkg.sv =====
package pps_pkg;

  localparam int PERIOD_W   = 16;
  localparam int SPEED_W    = 16;
  localparam int NUM_W      = 32;
  localparam int ALPHA_W    = 16;
  localparam int AVG_W      = 32;
  localparam int ACC_W      = AVG_W + 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = $clog2(NUM_W);

  localparam logic [NUM_W-1:0]   NUMERATOR_RESET = NUM_W'(909091);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = ALPHA_W'(11916);

  // register index, taken from paddr[2]
  localparam logic REG_NUMERATOR = 1'b0;
  localparam logic REG_ALPHA     = 1'b1;

  typedef struct packed {
    logic [NUM_W-1:0]   numerator;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

endpackage

// ===== rtl/pps_if.sv =====
interface pps_in_if import pps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] period_ticks;

  modport source (output valid, output period_ticks, input ready);
  modport sink   (input valid, input period_ticks, output ready);
endinterface

interface pps_out_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] raw_speed;
  logic [SPEED_W-1:0] average_speed;
  logic               saturated;

  modport source (output valid, output raw_speed, output average_speed, output saturated,
                  input ready);
  modport sink   (input valid, input raw_speed, input average_speed, input saturated,
                  output ready);
endinterface

// ===== rtl/pps_cfg_regs.sv =====
module pps_cfg_regs import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NUMERATOR: cfg_nxt.numerator = pwdata[NUM_W-1:0];
        REG_ALPHA:     cfg_nxt.alpha     = pwdata[ALPHA_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.numerator <= NUMERATOR_RESET;
      cfg_r.alpha     <= ALPHA_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUMERATOR: prdata = CFG_DATA_W'(cfg_r.numerator);
      REG_ALPHA:     prdata = CFG_DATA_W'(cfg_r.alpha);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pulse_period_speed_ema.sv =====
// Period-based tachometer. Each input transaction carries the timer tick count between two
// wheel pulses; the block divides speed_numerator by it to get raw speed (unsigned Q8.8,
// saturated at 65535, flagged when the period is zero or the quotient overflows) and folds
// that into a moving average weighted by alpha_weight (Q0.16), which is kept with 16 extra
// fraction bits and reported truncated to Q8.8. One result transaction per input. All
// arithmetic runs through a single 34-bit adder/subtractor under a small sequencer: a
// restoring divide of 32 steps (one quotient bit per cycle), one subtract, a 16-step
// shift-add multiply over the alpha bits and a final add. A pulse with a zero period skips
// the divide. The input is not ready while the sequencer works on a pulse.
// A finished result waits in an output register, so the next pulse can be accepted while it
// is still pending. Registers: speed_numerator at byte address 0, alpha_weight at 4.
module pulse_period_speed_ema import pps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pps_in_if.sink                in_ch,
  pps_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ALPHA_W - 1);

  cfg_t cfg;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] div_r, div_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [ACC_W-1:0]    dif_r, dif_nxt;
  logic [ALPHA_W-1:0]  alpha_r, alpha_nxt;
  logic [AVG_W-1:0]    avg_r, avg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SPEED_W-1:0]  out_raw_r, out_raw_nxt;
  logic [SPEED_W-1:0]  out_avg_r, out_avg_nxt;
  logic                out_sat_r, out_sat_nxt;

  // shared adder/subtractor
  logic [ACC_W-1:0] op_a, op_b, sum;
  logic             op_sub;

  logic [PERIOD_W:0]   rem_sh;
  logic [SPEED_W-1:0]  raw_speed;
  logic                sat;
  logic [ACC_W-1:0]    mul_t;
  logic                in_take;

  pps_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;

  assign rem_sh    = {rem_r, quo_r[NUM_W-1]};
  assign sat       = |quo_r[NUM_W-1:SPEED_W];
  assign raw_speed = sat ? {SPEED_W{1'b1}} : quo_r[SPEED_W-1:0];
  assign sum       = op_a + (op_sub ? ~op_b : op_b) + ACC_W'(op_sub);
  assign mul_t     = alpha_r[0] ? sum : acc_r;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    unique case (state_r)
      S_DIV: begin
        op_a   = ACC_W'(rem_sh);
        op_b   = ACC_W'(div_r);
        op_sub = 1'b1;
      end
      S_DIFF: begin
        op_a   = ACC_W'({raw_speed, {(AVG_W-SPEED_W){1'b0}}});
        op_b   = ACC_W'(avg_r);
        op_sub = 1'b1;
      end
      S_MUL: begin
        op_a = acc_r;
        op_b = dif_r;
      end
      S_ADD: begin
        op_a = ACC_W'(avg_r);
        op_b = acc_r;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    acc_nxt       = acc_r;
    dif_nxt       = dif_r;
    alpha_nxt     = alpha_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_raw_nxt   = out_raw_r;
    out_avg_nxt   = out_avg_r;
    out_sat_nxt   = out_sat_r;

    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          rem_nxt = '0;
          cnt_nxt = '0;
          div_nxt = in_ch.period_ticks[PERIOD_W-1:0];
          if (in_ch.period_ticks[PERIOD_W-1:0] == '0) begin
            // zero period: force an out-of-range quotient
            quo_nxt   = '1;
            state_nxt = S_DIFF;
          end else begin
            quo_nxt   = cfg.numerator;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (!sum[ACC_W-1]) begin
          rem_nxt = sum[PERIOD_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[PERIOD_W-1:0];
          quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        // signed gap between sample and average
        dif_nxt   = sum;
        acc_nxt   = '0;
        alpha_nxt = cfg.alpha;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // lsb-first shift-add, low product bits fall off (floor of alpha * gap / 2^16)
        acc_nxt   = {mul_t[ACC_W-1], mul_t[ACC_W-1:1]};
        alpha_nxt = {1'b0, alpha_r[ALPHA_W-1:1]};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        avg_nxt   = sum[AVG_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_speed;
          out_avg_nxt   = avg_r[AVG_W-1 -: SPEED_W];
          out_sat_nxt   = sat;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    acc_r     <= acc_nxt;
    dif_r     <= dif_nxt;
    alpha_r   <= alpha_nxt;
    out_raw_r <= out_raw_nxt;
    out_avg_r <= out_avg_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.raw_speed     = out_raw_r;
  assign out_ch.average_speed = out_avg_r;
  assign out_ch.saturated     = out_sat_r;

endmodule
